### sv/md5_pkg.sv
// MD5 digest package: payload structs, state codes, round tables and index helper.
// Used by md5_round_core, md5_msg_buf, md5_message_digest and md5_checker.
package md5_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } md5_req_type;

   typedef struct packed {
      logic [31:0] digest_word0;
      logic [31:0] digest_word1;
      logic [31:0] digest_word2;
      logic [31:0] digest_word3;
   } md5_rsp_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } md5_chain_type;

   typedef struct packed {
      logic       wr_en;
      logic [3:0] wr_addr;
      logic [31:0] wr_data;
   } md5_wr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_PAD_HEAD,
      ST_ZERO,
      ST_LEN_LO,
      ST_LEN_HI,
      ST_EMIT
   } md5_state_type;

   typedef enum logic [1:0] {
      AFT_IDLE,
      AFT_PAD,
      AFT_ZERO,
      AFT_EMIT
   } md5_after_type;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;
   localparam md5_chain_type CHAIN_IV = '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};

   localparam logic [31:0] PAD_BYTE    = 32'h00000080;
   localparam logic [4:0]  BLOCK_WORDS = 5'd16;
   localparam logic [4:0]  LEN_LO_WORD = 5'd14;
   localparam logic [3:0]  LEN_LO_ADDR = 4'd14;
   localparam logic [3:0]  LEN_HI_ADDR = 4'd15;
   localparam logic [5:0]  LAST_POS    = 6'd63;
   localparam logic [5:0]  LAST_ROUND  = 6'd63;

   localparam logic [31:0] K_TABLE [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] S_TABLE [64] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd7, 5'd12, 5'd17, 5'd22,
      5'd7, 5'd12, 5'd17, 5'd22, 5'd7, 5'd12, 5'd17, 5'd22,
      5'd5, 5'd9,  5'd14, 5'd20, 5'd5, 5'd9,  5'd14, 5'd20,
      5'd5, 5'd9,  5'd14, 5'd20, 5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd4, 5'd11, 5'd16, 5'd23,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd4, 5'd11, 5'd16, 5'd23,
      5'd6, 5'd10, 5'd15, 5'd21, 5'd6, 5'd10, 5'd15, 5'd21,
      5'd6, 5'd10, 5'd15, 5'd21, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // Message word used by a round.
   function automatic logic [3:0] msg_index(input logic [5:0] rnd);
      logic [3:0] i;
      logic [3:0] g;
      i = rnd[3:0];
      unique case (rnd[5:4])
         2'd0: g = i;
         2'd1: g = 4'((i << 2) + i + 4'd1);
         2'd2: g = 4'((i << 1) + i + 4'd5);
         2'd3: g = 4'((i << 3) - i);
         default: g = i;
      endcase
      return g;
   endfunction

endpackage

### sv/md5_msg_buf.sv
// MD5 message block store: 16 x 32-bit synchronous RAM, registered read.
// Depends on md5_pkg for the write command struct.
module md5_msg_buf
   import md5_pkg::*;
(
   input  logic        clock,
   input  md5_wr_type  wr,
   input  logic [3:0]  rd_addr,
   output logic [31:0] rd_data
);

   logic [31:0] mem [16];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         mem[wr.wr_addr] <= wr.wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/md5_round_core.sv
// MD5 compression engine: one round per cycle, chain value register and final add.
// Depends on md5_pkg for the round tables, msg_index and the chain struct.
module md5_round_core
   import md5_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          chain_init,
   input  logic [31:0]   rd_data,
   output logic [3:0]    rd_addr,
   output logic          done,
   output md5_chain_type chain
);

   logic          busy_ff, busy_in;
   logic          fin_ff, fin_in;
   logic [5:0]    rnd_ff, rnd_in;
   md5_chain_type work_ff, work_in;
   md5_chain_type chain_ff, chain_in;
   logic [31:0]   f_val;
   logic [31:0]   sum;
   logic [63:0]   rot_dbl;
   logic [31:0]   b_new;

   always_comb begin
      unique case (rnd_ff[5:4])
         2'd0: f_val = (work_ff.b & work_ff.c) | (~work_ff.b & work_ff.d);
         2'd1: f_val = (work_ff.d & work_ff.b) | (~work_ff.d & work_ff.c);
         2'd2: f_val = work_ff.b ^ work_ff.c ^ work_ff.d;
         2'd3: f_val = work_ff.c ^ (work_ff.b | ~work_ff.d);
         default: f_val = '0;
      endcase
      sum     = work_ff.a + f_val + K_TABLE[rnd_ff] + rd_data;
      rot_dbl = {sum, sum} << S_TABLE[rnd_ff];
      b_new   = work_ff.b + rot_dbl[63:32];
   end

   // Prefetch the word for the next round; round 0 reads word 0 on start.
   assign rd_addr = busy_ff ? msg_index(6'(rnd_ff + 6'd1)) : 4'd0;

   always_comb begin
      busy_in  = busy_ff;
      fin_in   = 1'b0;
      rnd_in   = rnd_ff;
      work_in  = work_ff;
      chain_in = chain_ff;
      if (start) begin
         busy_in = 1'b1;
         rnd_in  = '0;
         work_in = chain_ff;
      end else if (busy_ff) begin
         work_in = '{a: work_ff.d, b: b_new, c: work_ff.b, d: work_ff.c};
         rnd_in  = 6'(rnd_ff + 6'd1);
         if (rnd_ff == LAST_ROUND) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
      if (fin_ff) begin
         chain_in.a = chain_ff.a + work_ff.a;
         chain_in.b = chain_ff.b + work_ff.b;
         chain_in.c = chain_ff.c + work_ff.c;
         chain_in.d = chain_ff.d + work_ff.d;
      end
      if (chain_init) begin
         chain_in = CHAIN_IV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         fin_ff   <= 1'b0;
         rnd_ff   <= '0;
         chain_ff <= CHAIN_IV;
      end else begin
         busy_ff  <= busy_in;
         fin_ff   <= fin_in;
         rnd_ff   <= rnd_in;
         chain_ff <= chain_in;
      end
      work_ff <= work_in;
   end

   assign done  = fin_ff;
   assign chain = chain_ff;

endmodule

### sv/md5_message_digest.sv
// MD5 digest top level: request intake, padding sequencer and digest output register.
// Depends on md5_pkg, md5_msg_buf and md5_round_core.
//
// Usage: each request carries one message byte (byte_present) and/or an end
// marker (end_of_message). Bytes pack little-endian into a 16-word block RAM.
// A request with end_of_message returns one response with the four digest
// words; other requests return nothing.
// Block hashing: the 64th byte of a block starts the round engine, and req_ready
// stays low while it runs its 64 rounds, one per cycle through the single RAM
// read port, and then the chain add.
// End of message: the pad word, up to 13 zero-fill writes and a step to leave
// the fill, 2 length writes, the rounds and chain add, and the output load;
// when 8 or fewer bytes of the block remain, the fill runs to the end of the
// block, which is hashed, and 14 zero writes follow in a fresh block.
// The digest is visible on rsp_valid the cycle after the output load.
// The response sits in an output register: the block keeps taking requests
// while rsp_ready is low and only waits before loading the next digest.
// Reset clears the byte count, loads the MD5 initial chain and drops rsp_valid.
module md5_message_digest
   import md5_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  md5_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output md5_rsp_type rsp_data
);

   md5_state_type state_ff, state_in;
   md5_after_type after_ff, after_in;
   logic          long_ff, long_in;
   logic [4:0]    zidx_ff, zidx_in;
   logic [60:0]   count_ff, count_in;
   logic [31:0]   word_ff, word_in;
   logic          rsp_valid_ff, rsp_valid_in;
   md5_rsp_type   rsp_data_ff, rsp_data_in;

   md5_wr_type    wr;
   logic          core_start;
   logic          chain_init;
   logic          core_done;
   logic [3:0]    rd_addr;
   logic [31:0]   rd_data;
   md5_chain_type chain;

   logic [5:0]    pos;
   logic [4:0]    lane_shift;
   logic [31:0]   lane_mask;
   logic [31:0]   keep_mask;
   logic [4:0]    zero_limit;
   logic          accept;

   assign pos        = count_ff[5:0];
   assign lane_shift = {pos[1:0], 3'b000};
   assign lane_mask  = 32'h000000ff << lane_shift;
   assign keep_mask  = ~(32'hffffffff << lane_shift);
   assign zero_limit = long_ff ? BLOCK_WORDS : LEN_LO_WORD;
   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      after_in     = after_ff;
      long_in      = long_ff;
      zidx_in      = zidx_ff;
      count_in     = count_ff;
      word_in      = word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr           = '{wr_en: 1'b0, wr_addr: pos[5:2], wr_data: word_ff};
      core_start   = 1'b0;
      chain_init   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.byte_present) begin
                  word_in = (word_ff & ~lane_mask)
                          | (32'(req_data.data_byte) << lane_shift);
                  count_in = 61'(count_ff + 61'd1);
                  wr = '{wr_en: (pos[1:0] == 2'd3), wr_addr: pos[5:2], wr_data: word_in};
                  if (pos == LAST_POS) begin
                     core_start = 1'b1;
                     after_in   = req_data.end_of_message ? AFT_PAD : AFT_IDLE;
                     state_in   = ST_HASH;
                  end else if (req_data.end_of_message) begin
                     state_in = ST_PAD_HEAD;
                  end
               end else if (req_data.end_of_message) begin
                  state_in = ST_PAD_HEAD;
               end
            end
         end
         ST_HASH: begin
            if (core_done) begin
               unique case (after_ff)
                  AFT_IDLE: state_in = ST_IDLE;
                  AFT_PAD:  state_in = ST_PAD_HEAD;
                  AFT_ZERO: state_in = ST_ZERO;
                  AFT_EMIT: state_in = ST_EMIT;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_PAD_HEAD: begin
            // Keep the bytes already in the word, then the 0x80 marker.
            wr = '{wr_en: 1'b1, wr_addr: pos[5:2],
                   wr_data: (word_ff & keep_mask) | (PAD_BYTE << lane_shift)};
            long_in  = (pos[5:3] == 3'd7);
            zidx_in  = 5'({1'b0, pos[5:2]} + 5'd1);
            state_in = ST_ZERO;
         end
         ST_ZERO: begin
            if (zidx_ff < zero_limit) begin
               wr      = '{wr_en: 1'b1, wr_addr: zidx_ff[3:0], wr_data: '0};
               zidx_in = 5'(zidx_ff + 5'd1);
            end else if (long_ff) begin
               // No room for the length: hash this block, then fill a fresh one.
               core_start = 1'b1;
               after_in   = AFT_ZERO;
               long_in    = 1'b0;
               zidx_in    = '0;
               state_in   = ST_HASH;
            end else begin
               state_in = ST_LEN_LO;
            end
         end
         ST_LEN_LO: begin
            wr = '{wr_en: 1'b1, wr_addr: LEN_LO_ADDR, wr_data: {count_ff[28:0], 3'b000}};
            state_in = ST_LEN_HI;
         end
         ST_LEN_HI: begin
            wr = '{wr_en: 1'b1, wr_addr: LEN_HI_ADDR, wr_data: count_ff[60:29]};
            core_start = 1'b1;
            after_in   = AFT_EMIT;
            state_in   = ST_HASH;
         end
         ST_EMIT: begin
            // Hold until the previous digest has been taken.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{digest_word0: chain.a, digest_word1: chain.b,
                                digest_word2: chain.c, digest_word3: chain.d};
               chain_init   = 1'b1;
               count_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         after_ff     <= AFT_IDLE;
         long_ff      <= 1'b0;
         zidx_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         after_ff     <= after_in;
         long_ff      <= long_in;
         zidx_ff      <= zidx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff     <= word_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   md5_msg_buf u_msg_buf (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   md5_round_core u_round_core (
      .clock      (clock),
      .reset      (reset),
      .start      (core_start),
      .chain_init (chain_init),
      .rd_data    (rd_data),
      .rd_addr    (rd_addr),
      .done       (core_done),
      .chain      (chain)
   );

endmodule

### sv/md5_checker.sv
// MD5 digest port checker: response hold, reset behavior and busy windows.
// Depends on md5_pkg; bound to md5_message_digest.
module md5_checker
   import md5_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input md5_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input md5_rsp_type rsp_data
);

   // A stalled response holds its digest.
   rsp_hold_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   reset_clear_a: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // An end marker starts padding, or hashing first if it completes a block, so the next cycle is busy.
   end_busy_a: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.end_of_message |=> !req_ready)
      else $error("request taken right after an end marker");

   // A digest is only loaded while intake is closed.
   rsp_busy_a: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("digest appeared without a busy cycle");

endmodule

bind md5_message_digest md5_checker u_md5_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### bench/md5_message_digest_tb.sv
// Testbench for md5_message_digest: directed and random messages, byte by byte, against an
// in-bench MD5 predictor. Depends on md5_pkg for the request and response payload types.
`timescale 1ns / 100ps

module testbench;
   import md5_pkg::*;

   typedef struct packed {
      logic        drain_first;
      md5_req_type req;
   } feed_item_type;

   localparam logic [31:0] SINE_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // Rotate amounts, four per round group.
   localparam int ROT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

   localparam int BOUNDARY_LEN [12] = '{55, 56, 57, 63, 64, 65, 119, 120, 121, 127, 128, 129};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   md5_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   md5_rsp_type rsp_data;

   // Predictor state
   logic [31:0] hash_chain [4];
   logic [31:0] msg_block [16];
   logic [60:0] msg_bytes;

   feed_item_type request_feed [$];
   md5_rsp_type   digest_due [$];

   int errors = 0;
   int requests_taken = 0;
   int digests_checked = 0;
   int longest_msg = 0;

   md5_message_digest i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void load_initial_chain();
      hash_chain[0] = 32'h67452301;
      hash_chain[1] = 32'hefcdab89;
      hash_chain[2] = 32'h98badcfe;
      hash_chain[3] = 32'h10325476;
   endfunction

   function automatic void md5_compress();
      logic [31:0] a, b, c, d, f, t, sum;
      int g, r, s;
      a = hash_chain[0];
      b = hash_chain[1];
      c = hash_chain[2];
      d = hash_chain[3];
      for (r = 0; r < 64; r++) begin
         case (r / 16)
            0: begin
               f = (b & c) | (~b & d);
               g = r;
            end
            1: begin
               f = (d & b) | (~d & c);
               g = (5 * r + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * r + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * r) % 16;
            end
         endcase
         s = ROT_AMT[(r / 16) * 4 + (r % 4)];
         sum = a + f + SINE_K[r] + msg_block[g];
         t = d;
         d = c;
         c = b;
         b = b + ((sum << s) | (sum >> (32 - s)));
         a = t;
      end
      hash_chain[0] = hash_chain[0] + a;
      hash_chain[1] = hash_chain[1] + b;
      hash_chain[2] = hash_chain[2] + c;
      hash_chain[3] = hash_chain[3] + d;
   endfunction

   // Advance the predictor by one request; queue a digest on an end marker.
   function automatic void absorb_request(md5_req_type r);
      int pos, w, lane, j;
      logic [31:0] keep;
      logic [63:0] bit_len;
      md5_rsp_type dig;
      if (r.byte_present) begin
         pos = int'(msg_bytes[5:0]);
         w = pos / 4;
         lane = (pos % 4) * 8;
         msg_block[w][lane +: 8] = r.data_byte;
         msg_bytes = msg_bytes + 61'd1;
         if (pos == 63) md5_compress();
      end
      if (r.end_of_message) begin
         pos = int'(msg_bytes[5:0]);
         w = pos / 4;
         lane = (pos % 4) * 8;
         keep = (lane == 0) ? 32'h0 : (32'hffffffff >> (32 - lane));
         msg_block[w] = (msg_block[w] & keep) | (32'h80 << lane);
         for (j = w + 1; j < 16; j++) msg_block[j] = 32'h0;
         // no room for the length: flush this block and pad a fresh one
         if (pos >= 56) begin
            md5_compress();
            for (j = 0; j < 16; j++) msg_block[j] = 32'h0;
         end
         bit_len = {msg_bytes, 3'b000};
         msg_block[14] = bit_len[31:0];
         msg_block[15] = bit_len[63:32];
         md5_compress();
         dig.digest_word0 = hash_chain[0];
         dig.digest_word1 = hash_chain[1];
         dig.digest_word2 = hash_chain[2];
         dig.digest_word3 = hash_chain[3];
         digest_due.push_back(dig);
         load_initial_chain();
         msg_bytes = '0;
      end
   endfunction

   // Random stall, except in a quiet window of the run.
   function automatic bit take_break();
      if (requests_taken >= 400 && requests_taken < 650) return 1'b0;
      return $urandom_range(99) < 22;
   endfunction

   task automatic push_item(input logic [7:0] data, input logic present, input logic last,
                            input logic drain);
      feed_item_type item;
      item.drain_first = drain;
      item.req.data_byte = data;
      item.req.byte_present = present;
      item.req.end_of_message = last;
      request_feed.push_back(item);
   endtask

   // Queue one message of len bytes, with stray no-op requests mixed in.
   task automatic queue_message(input int len, input logic drain, inout int counted);
      int k;
      logic fold_end;
      logic first;
      fold_end = (len > 0) && ($urandom_range(1) == 1);
      first = drain;
      for (k = 0; k < len; k++) begin
         if ($urandom_range(99) < 5) begin
            push_item(8'($urandom), 1'b0, 1'b0, first);
            first = 1'b0;
         end
         push_item(8'($urandom), 1'b1, fold_end && (k == len - 1), first);
         first = 1'b0;
         counted++;
      end
      if (!fold_end) begin
         push_item(8'($urandom), 1'b0, 1'b1, first);
         counted++;
      end
      if (len > longest_msg) longest_msg = len;
   endtask

   // Driver: hold a request until taken, then fetch the next one from the feed.
   always @(posedge clock) begin : drive
      logic        next_valid;
      md5_req_type next_data;
      feed_item_type head;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         next_data = req_data;
         if (req_valid && req_ready) begin
            absorb_request(req_data);
            requests_taken++;
            next_valid = 1'b0;
         end
         if (!next_valid && request_feed.size() > 0) begin
            if (!(request_feed[0].drain_first && digest_due.size() > 0) && !take_break()) begin
               head = request_feed.pop_front();
               next_valid = 1'b1;
               next_data = head.req;
            end
         end
         req_valid <= next_valid;
         req_data <= next_data;
      end
   end

   task automatic check_word(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %08h, got %08h", name, want, got);
         errors++;
      end
   endtask

   // Monitor: compare each digest with the oldest prediction.
   always @(posedge clock) begin : watch
      md5_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (digest_due.size() == 0) begin
               $error("digest %08h %08h %08h %08h with no request pending",
                      rsp_data.digest_word0, rsp_data.digest_word1,
                      rsp_data.digest_word2, rsp_data.digest_word3);
               errors++;
            end else begin
               want = digest_due.pop_front();
               check_word("digest_word0", want.digest_word0, rsp_data.digest_word0);
               check_word("digest_word1", want.digest_word1, rsp_data.digest_word1);
               check_word("digest_word2", want.digest_word2, rsp_data.digest_word2);
               check_word("digest_word3", want.digest_word3, rsp_data.digest_word3);
               digests_checked++;
            end
         end
         rsp_ready <= !take_break();
      end
   end

   initial begin
      #2_000_000;
      $display("** md5_message_digest: FAILED **");
      $finish;
   end

   initial begin : stimulus
      int counted;
      int messages;
      int len;
      int pick;
      load_initial_chain();
      for (int j = 0; j < 16; j++) msg_block[j] = 32'h0;
      msg_bytes = '0;
      counted = 0;
      messages = 0;

      // Directed: empty message, no-op requests, byte with end, lane extremes
      push_item(8'h00, 1'b0, 1'b1, 1'b0);
      push_item(8'ha5, 1'b0, 1'b0, 1'b0);
      push_item(8'h61, 1'b1, 1'b0, 1'b1);
      push_item(8'h62, 1'b1, 1'b0, 1'b0);
      push_item(8'h63, 1'b1, 1'b1, 1'b0);
      push_item(8'h00, 1'b1, 1'b0, 1'b0);
      push_item(8'hff, 1'b0, 1'b1, 1'b0);
      push_item(8'hff, 1'b1, 1'b1, 1'b0);
      push_item(8'hff, 1'b0, 1'b0, 1'b0);
      push_item(8'h3c, 1'b0, 1'b1, 1'b0);
      push_item(8'h80, 1'b1, 1'b0, 1'b0);
      push_item(8'h7f, 1'b1, 1'b0, 1'b0);
      push_item(8'h01, 1'b1, 1'b0, 1'b0);
      push_item(8'hfe, 1'b1, 1'b0, 1'b0);
      push_item(8'h55, 1'b1, 1'b0, 1'b0);
      push_item(8'haa, 1'b0, 1'b1, 1'b0);
      push_item(8'h00, 1'b0, 1'b0, 1'b0);
      push_item(8'h00, 1'b0, 1'b1, 1'b1);

      // Random messages: mostly short, some on the padding boundaries, a few long
      while (counted < 1100 || messages < 20) begin
         pick = $urandom_range(99);
         if (pick < 60) len = $urandom_range(15);
         else if (pick < 80) len = $urandom_range(70, 16);
         else if (pick < 95) len = BOUNDARY_LEN[$urandom_range(11)];
         else len = $urandom_range(300, 130);
         queue_message(len, (messages % 8) == 3, counted);
         messages++;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (request_feed.size() > 0 || req_valid) @(posedge clock);
      while (digest_due.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Covered %0d requests in %0d random messages plus directed ones,",
               requests_taken, messages);
      $display("%0d digests checked, longest message %0d bytes", digests_checked, longest_msg);
      if (errors == 0) begin
         $display("** md5_message_digest: PASSED **");
      end else begin
         $display("** md5_message_digest: FAILED **");
      end
      $finish;
   end

endmodule
